@@ rtl/aho_corasick_score_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Aho-Corasick score matcher
// Concurrent property wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AHO_CORASICK_SCORE_MATCHER_MACROS_SVH
`define AHO_CORASICK_SCORE_MATCHER_MACROS_SVH

// Same-cycle implication
`define ACSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ACSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/acsm_pkg.sv @@
// ----------------------------------------------------------------------------
// acsm_pkg
// Item types, command and status codes and saturating add for the matcher.
// ----------------------------------------------------------------------------
package acsm_pkg;

  localparam int DEF_MAX_STATES = 256;
  localparam int DEF_SYMBOLS    = 4;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_END_PAT  = 3'd1;
  localparam logic [2:0] CMD_BUILD    = 3'd2;
  localparam logic [2:0] CMD_TEXT     = 3'd3;
  localparam logic [2:0] CMD_END_TEXT = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         symbol;
    logic signed [31:0] pattern_score;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] total_score;
    logic [1:0]         status;
  } out_item_t;

  // Signed 32-bit add clamped to the signed range
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

endpackage

@@ rtl/aho_corasick_score_matcher.sv @@
// ----------------------------------------------------------------------------
// aho_corasick_score_matcher
// Trie build, breadth-first failure-link build and scored text matching.
// ----------------------------------------------------------------------------
// One item is handled at a time; the result goes to an output register, so a
// new item is taken while an earlier result waits. A text symbol walks the
// failure links one step at a time (the walk reads child row and fail link
// memories once per step), and a build walks them likewise for each trie edge
// out of a non-root state. After reset and after a clear command a clearing
// pass writes zero to the child row and score memories, one entry a cycle,
// with no item taken.
`include "aho_corasick_score_matcher_macros.svh"

module aho_corasick_score_matcher #(
  parameter int MAX_STATES = acsm_pkg::DEF_MAX_STATES,
  parameter int SYMBOLS    = acsm_pkg::DEF_SYMBOLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acsm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output acsm_pkg::out_item_t out_data
);
  import acsm_pkg::*;

  localparam int SW   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int QW   = SW + 1;
  localparam int SYMW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SIW  = SYMW + 1;

  typedef logic [SYMBOLS-1:0][SW-1:0] row_t;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_INS   = 14'b00000000000100,
    S_ENDP  = 14'b00000000001000,
    S_WALK  = 14'b00000000010000,
    S_TADD  = 14'b00000000100000,
    S_BPOP  = 14'b00000001000000,
    S_BU    = 14'b00000010000000,
    S_BURD  = 14'b00000100000000,
    S_BSYM  = 14'b00001000000000,
    S_BSV   = 14'b00010000000000,
    S_BSW   = 14'b00100000000000,
    S_BSADD = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_t;

  // Memories
  row_t               ch_mem [MAX_STATES];
  logic [SW-1:0]      fl_mem [MAX_STATES];
  logic signed [31:0] sc_mem [MAX_STATES];
  logic [SW-1:0]      q_mem  [MAX_STATES];

  logic               ch_we, ch_re, fl_we, fl_re, sc_we, sc_re, q_we, q_re;
  logic [SW-1:0]      ch_waddr, ch_raddr, fl_waddr, fl_raddr;
  logic [SW-1:0]      sc_waddr, sc_raddr, q_waddr, q_raddr;
  row_t               ch_wdata, ch_rdata;
  logic [SW-1:0]      fl_wdata, fl_rdata, q_wdata, q_rdata;
  logic signed [31:0] sc_wdata, sc_rdata;

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
    if (ch_re) ch_rdata <= ch_mem[ch_raddr];
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    if (fl_re) fl_rdata <= fl_mem[fl_raddr];
    if (sc_we) sc_mem[sc_waddr] <= sc_wdata;
    if (sc_re) sc_rdata <= sc_mem[sc_raddr];
    if (q_we)  q_mem[q_waddr]   <= q_wdata;
    if (q_re)  q_rdata  <= q_mem[q_raddr];
  end

  // Registers
  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [SW-1:0]      cursor_r, cursor_nxt, count_r, count_nxt, match_r, match_nxt;
  logic signed [31:0] total_r, total_nxt, sv_r, sv_nxt;
  logic               built_r, built_nxt, wbuild_r, wbuild_nxt, clr_resp_r, clr_resp_nxt;
  logic [SW-1:0]      node_r, node_nxt, u_r, u_nxt, failu_r, failu_nxt;
  logic [SW-1:0]      v_r, v_nxt, w_r, w_nxt, clr_r, clr_nxt;
  logic [SYMW-1:0]    wsym_r, wsym_nxt;
  logic [QW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [SIW-1:0]     symi_r, symi_nxt;
  row_t               rowu_r, rowu_nxt;
  out_item_t          res_r, res_nxt, out_data_r;
  logic               out_valid_r;

  logic               in_acc, sym_ok, out_free;
  logic [SYMW-1:0]    in_sym, isym;
  logic [SW-1:0]      wchild, ins_child, bvec, mtgt;
  row_t               row_mod;
  logic signed [31:0] tsum;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign sym_ok   = (32'(in_data.symbol) < SYMBOLS);
  assign in_sym   = SYMW'(in_data.symbol);
  assign isym     = SYMW'(item_r.symbol);
  assign wchild   = ch_rdata[wsym_r];
  assign ins_child = ch_rdata[isym];
  assign bvec     = rowu_r[symi_r[SYMW-1:0]];
  assign mtgt     = (wchild != '0) ? wchild : node_r;
  assign tsum     = sat_add(total_r, sc_rdata);

  always_comb begin
    row_mod       = ch_rdata;
    row_mod[isym] = count_r + SW'(1);
  end

  // Control sequencer
  always_comb begin
    state_nxt = state_r;   item_nxt = item_r;   cursor_nxt = cursor_r;
    count_nxt = count_r;   match_nxt = match_r; total_nxt = total_r;
    sv_nxt = sv_r;         built_nxt = built_r; wbuild_nxt = wbuild_r;
    clr_resp_nxt = clr_resp_r; node_nxt = node_r; u_nxt = u_r;
    failu_nxt = failu_r;   v_nxt = v_r;   w_nxt = w_r;   clr_nxt = clr_r;
    wsym_nxt = wsym_r;     head_nxt = head_r; tail_nxt = tail_r;
    symi_nxt = symi_r;     rowu_nxt = rowu_r; res_nxt = res_r;
    ch_we = 1'b0; ch_re = 1'b0; fl_we = 1'b0; fl_re = 1'b0;
    sc_we = 1'b0; sc_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
    ch_waddr = '0; ch_raddr = '0; fl_waddr = '0; fl_raddr = '0;
    sc_waddr = '0; sc_raddr = '0; q_waddr = '0; q_raddr = '0;
    ch_wdata = '0; fl_wdata = '0; sc_wdata = '0; q_wdata = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt  = in_data;
          state_nxt = S_RESP;
          res_nxt   = '{total_score: total_r, status: ST_OK};
          unique case (in_data.command)
            CMD_INSERT: begin
              if (sym_ok && !built_r) begin
                ch_re = 1'b1; ch_raddr = cursor_r;
                state_nxt = S_INS;
              end
            end
            CMD_END_PAT: begin
              if (!built_r) begin
                sc_re = 1'b1; sc_raddr = cursor_r;
                state_nxt = S_ENDP;
              end
            end
            CMD_BUILD: begin
              if (!built_r) begin
                fl_we = 1'b1; fl_waddr = '0; fl_wdata = '0;
                q_we  = 1'b1; q_waddr  = '0; q_wdata  = '0;
                head_nxt  = '0;
                tail_nxt  = QW'(1);
                state_nxt = S_BPOP;
              end
            end
            CMD_TEXT: begin
              if (sym_ok) begin
                if (!built_r) begin
                  res_nxt.status = ST_NOT_BUILT;
                end else begin
                  ch_re = 1'b1; ch_raddr = match_r;
                  fl_re = 1'b1; fl_raddr = match_r;
                  node_nxt   = match_r;
                  wsym_nxt   = in_sym;
                  wbuild_nxt = 1'b0;
                  state_nxt  = S_WALK;
                end
              end
            end
            CMD_END_TEXT: begin
              if (!built_r) res_nxt.status = ST_NOT_BUILT;
              total_nxt = '0;
              match_nxt = '0;
            end
            CMD_CLEAR: begin
              count_nxt = '0; cursor_nxt = '0; match_nxt = '0;
              total_nxt = '0; built_nxt = 1'b0;
              clr_nxt = '0; clr_resp_nxt = 1'b1;
              state_nxt = S_CLR;
            end
            default: ;
          endcase
        end
      end

      // Zero the child rows and scores, one entry a cycle
      S_CLR: begin
        ch_we = 1'b1; ch_waddr = clr_r; ch_wdata = '0;
        sc_we = 1'b1; sc_waddr = clr_r; sc_wdata = '0;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(MAX_STATES - 1)) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
          res_nxt   = '{total_score: '0, status: ST_OK};
        end
      end

      // Trie insert: follow an existing child or allocate a new state
      S_INS: begin
        state_nxt = S_RESP;
        res_nxt   = '{total_score: total_r, status: ST_OK};
        if (ins_child != '0) begin
          cursor_nxt = ins_child;
        end else if (count_r == SW'(MAX_STATES - 1)) begin
          res_nxt.status = ST_FULL;
        end else begin
          ch_we = 1'b1; ch_waddr = cursor_r; ch_wdata = row_mod;
          count_nxt  = count_r + SW'(1);
          cursor_nxt = count_r + SW'(1);
        end
      end

      S_ENDP: begin
        sc_we = 1'b1; sc_waddr = cursor_r;
        sc_wdata   = sat_add(sc_rdata, item_r.pattern_score);
        cursor_nxt = '0;
        state_nxt  = S_RESP;
        res_nxt    = '{total_score: total_r, status: ST_OK};
      end

      // Failure walk: one link per cycle until a child exists or at root
      S_WALK: begin
        if (node_r == '0 || wchild != '0) begin
          if (wbuild_r) begin
            w_nxt     = wchild;
            state_nxt = S_BSV;
          end else begin
            match_nxt = mtgt;
            sc_re = 1'b1; sc_raddr = mtgt;
            state_nxt = S_TADD;
          end
        end else begin
          node_nxt = fl_rdata;
          ch_re = 1'b1; ch_raddr = fl_rdata;
          fl_re = 1'b1; fl_raddr = fl_rdata;
        end
      end

      S_TADD: begin
        total_nxt = tsum;
        state_nxt = S_RESP;
        res_nxt   = '{total_score: tsum, status: ST_OK};
      end

      // Breadth-first link build
      S_BPOP: begin
        if (head_r < tail_r) begin
          q_re = 1'b1; q_raddr = head_r[SW-1:0];
          head_nxt  = head_r + QW'(1);
          state_nxt = S_BU;
        end else begin
          built_nxt = 1'b1;
          state_nxt = S_RESP;
          res_nxt   = '{total_score: total_r, status: ST_OK};
        end
      end

      S_BU: begin
        u_nxt = q_rdata;
        ch_re = 1'b1; ch_raddr = q_rdata;
        fl_re = 1'b1; fl_raddr = q_rdata;
        state_nxt = S_BURD;
      end

      S_BURD: begin
        rowu_nxt  = ch_rdata;
        failu_nxt = fl_rdata;
        symi_nxt  = '0;
        state_nxt = S_BSYM;
      end

      S_BSYM: begin
        if (symi_r == SIW'(SYMBOLS)) begin
          state_nxt = S_BPOP;
        end else if (bvec == '0) begin
          symi_nxt = symi_r + SIW'(1);
        end else begin
          v_nxt = bvec;
          if (u_r == '0) begin
            w_nxt     = '0;
            state_nxt = S_BSV;
          end else begin
            node_nxt   = failu_r;
            wsym_nxt   = symi_r[SYMW-1:0];
            wbuild_nxt = 1'b1;
            ch_re = 1'b1; ch_raddr = failu_r;
            fl_re = 1'b1; fl_raddr = failu_r;
            state_nxt = S_WALK;
          end
        end
      end

      S_BSV: begin
        fl_we = 1'b1; fl_waddr = v_r; fl_wdata = w_r;
        sc_re = 1'b1; sc_raddr = v_r;
        state_nxt = S_BSW;
      end

      S_BSW: begin
        sv_nxt = sc_rdata;
        sc_re = 1'b1; sc_raddr = w_r;
        state_nxt = S_BSADD;
      end

      // Child score plus fail score, then enqueue the child if the queue has room
      S_BSADD: begin
        sc_we = 1'b1; sc_waddr = v_r; sc_wdata = sat_add(sv_r, sc_rdata);
        if (tail_r < QW'(MAX_STATES)) begin
          q_we = 1'b1; q_waddr = tail_r[SW-1:0]; q_wdata = v_r;
          tail_nxt = tail_r + QW'(1);
        end
        symi_nxt  = symi_r + SIW'(1);
        state_nxt = S_BSYM;
      end

      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cursor_r <= '0; count_r <= '0; match_r <= '0; total_r <= '0;
      built_r <= 1'b0; wbuild_r <= 1'b0; clr_resp_r <= 1'b0; clr_r <= '0;
      head_r <= '0; tail_r <= '0; symi_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cursor_r <= cursor_nxt; count_r <= count_nxt; match_r <= match_nxt;
      total_r <= total_nxt; built_r <= built_nxt; wbuild_r <= wbuild_nxt;
      clr_resp_r <= clr_resp_nxt; clr_r <= clr_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; symi_r <= symi_nxt;
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt; sv_r <= sv_nxt; node_r <= node_nxt; u_r <= u_nxt;
    failu_r <= failu_nxt; v_r <= v_nxt; w_r <= w_nxt; wsym_r <= wsym_nxt;
    rowu_r <= rowu_nxt; res_r <= res_nxt;
    if (state_r == S_RESP && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ACSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "item accepted but block not busy next cycle")
  `ACSM_ASSERT_NOW(a_queue_order, state_r == S_BPOP || state_r == S_BSYM,
    head_r <= tail_r, "build queue head passed tail")
  `ACSM_ASSERT_NEXT(a_result_loaded, state_r == S_RESP && out_free,
    out_valid_r && state_r == S_IDLE, "result not loaded on hand-off")

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for aho_corasick_score_matcher
// A table of directed items, then random sessions, is sent into the matcher.
// Each session loads patterns, builds the links and scores a text. Results are
// checked against typed rows or a behavioral model of the automaton kept here.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acsm_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         N_ITEMS    = 1350;
  localparam int         IDLE_LIMIT = 100000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // automaton mirror
  logic [7:0]         kid[1024];
  logic [7:0]         fail_of[256];
  logic signed [31:0] nscore[256];
  logic [7:0]         nstates;
  logic [7:0]         cursor;
  logic [7:0]         mstate;
  logic signed [31:0] total;
  bit                 built;

  out_item_t  pending[$];
  row_t       dir_rows[$];
  int         n_items, n_checked, n_errors, n_full, idle_cnt;
  int         send_idle_pct, stall_pct;

  aho_corasick_score_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(logic signed [31:0] a, logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fff_ffff;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic void clear_model();
    foreach (kid[i]) kid[i] = '0;
    foreach (fail_of[i]) fail_of[i] = '0;
    foreach (nscore[i]) nscore[i] = '0;
    nstates = '0;
    cursor  = '0;
    mstate  = '0;
    total   = '0;
    built   = 1'b0;
  endfunction

  // back off along failure links until sym has a child or the root is hit
  function automatic logic [7:0] follow_fail(logic [7:0] n, logic [1:0] sym);
    int g;
    g = 0;
    while (n != 0 && kid[{n, sym}] == 0 && g < 256) begin
      n = fail_of[n];
      g++;
    end
    return n;
  endfunction

  // breadth-first failure links, scores accumulate from the fail state
  function automatic void build_fail_links();
    logic [7:0] q[256];
    logic [7:0] u, v, w, f;
    int         head, tail;
    head = 0;
    tail = 1;
    q[0] = '0;
    fail_of[0] = '0;
    while (head < tail) begin
      u = q[head];
      head++;
      for (int s = 0; s < 4; s++) begin
        v = kid[{u, s[1:0]}];
        if (v == 0) continue;
        w = '0;
        if (u != 0) begin
          f = follow_fail(fail_of[u], s[1:0]);
          w = kid[{f, s[1:0]}];
        end
        fail_of[v] = w;
        nscore[v] = sat32(nscore[v], nscore[w]);
        if (tail < 256) begin
          q[tail] = v;
          tail++;
        end
      end
    end
    built = 1'b1;
  endfunction

  function automatic out_item_t score_step(in_item_t it);
    out_item_t  r;
    logic [9:0] idx;
    logic [7:0] s, c;
    r.status = ST_OK;
    case (it.command)
      CMD_INSERT: begin
        if (!built) begin
          idx = {cursor, it.symbol};
          if (kid[idx] != 0) begin
            cursor = kid[idx];
          end else if (nstates >= 8'd255) begin
            r.status = ST_FULL;
          end else begin
            nstates++;
            kid[idx] = nstates;
            cursor = nstates;
          end
        end
      end
      CMD_END_PAT: begin
        if (!built) begin
          nscore[cursor] = sat32(nscore[cursor], it.pattern_score);
          cursor = '0;
        end
      end
      CMD_BUILD: begin
        if (!built) build_fail_links();
      end
      CMD_TEXT: begin
        if (!built) begin
          r.status = ST_NOT_BUILT;
        end else begin
          s = follow_fail(mstate, it.symbol);
          c = kid[{s, it.symbol}];
          if (c != 0) s = c;
          mstate = s;
          total = sat32(total, nscore[s]);
        end
      end
      CMD_CLEAR: clear_model();
      default: ;
    endcase
    r.total_score = total;
    if (it.command == CMD_END_TEXT) begin
      if (!built) r.status = ST_NOT_BUILT;
      total = '0;
      mstate = '0;
    end
    return r;
  endfunction

  function automatic in_item_t mk(logic [2:0] cmd, logic [1:0] sym, logic signed [31:0] sc);
    in_item_t it;
    it.command = cmd;
    it.symbol = sym;
    it.pattern_score = sc;
    return it;
  endfunction

  function automatic void add_row(logic [2:0] cmd, logic [1:0] sym, logic signed [31:0] sc,
                                  bit typed, logic signed [31:0] tot, logic [1:0] st);
    row_t r;
    r.it = mk(cmd, sym, sc);
    r.typed = typed;
    r.want.total_score = tot;
    r.want.status = st;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // one item through the handshake; the expectation is queued at acceptance
  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    exp_r = score_step(it);
    if (exp_r.status == ST_FULL) n_full++;
    pending.insert(pending.size(), typed ? want : exp_r);
    n_items++;
  endtask

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(16)) - 8;
    endcase
  endfunction

  function automatic void set_idling();
    case (n_items * 5 / (N_ITEMS + 50))
      1: begin send_idle_pct = 83; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 83; end
      3: begin send_idle_pct = 33; stall_pct = 33; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endfunction

  // patterns, build, text; the second session loads the most and longest patterns
  task automatic run_session(int sess);
    logic [1:0] syms[$];
    int         starts[$], lens[$];
    int         n_pat, max_len, len, p;
    if (n_items > 0) send(mk(CMD_CLEAR, 2'($urandom), $urandom));
    n_pat = (sess == 1) ? 30 : $urandom_range(1, 6);
    max_len = (sess == 1) ? 12 : 4;
    if ($urandom_range(9) == 0) send(mk(CMD_TEXT, 2'($urandom), $urandom));
    if ($urandom_range(9) == 0) send(mk(CMD_END_TEXT, 2'($urandom), $urandom));
    for (int i = 0; i < n_pat; i++) begin
      len = $urandom_range(max_len);
      starts.insert(starts.size(), syms.size());
      lens.insert(lens.size(), len);
      for (int k = 0; k < len; k++) begin
        syms.insert(syms.size(), 2'($urandom));
        send(mk(CMD_INSERT, syms[$], $urandom));
      end
      send(mk(CMD_END_PAT, 2'($urandom), pick_score()));
    end
    set_idling();
    send(mk(CMD_BUILD, 2'($urandom), $urandom));
    if ($urandom_range(3) == 0) send(mk(CMD_BUILD, 2'($urandom), $urandom));
    len = $urandom_range(5, 40);
    for (int t = 0; t < len; t++) begin
      case ($urandom_range(19))
        0: send(mk(CMD_SPARE6 | 3'($urandom_range(1)), 2'($urandom), $urandom));
        1: send(mk(3'($urandom_range(1)), 2'($urandom), $urandom));
        2: send(mk(CMD_END_TEXT, 2'($urandom), $urandom));
        3, 4, 5, 6, 7, 8, 9, 10: begin
          p = $urandom_range(starts.size() - 1);
          for (int k = 0; k < lens[p]; k++)
            send(mk(CMD_TEXT, syms[starts[p] + k], $urandom));
        end
        default: send(mk(CMD_TEXT, 2'($urandom), $urandom));
      endcase
    end
    send(mk(CMD_END_TEXT, 2'($urandom), $urandom));
    set_idling();
  endtask

  // result side: random stall and in-order compare
  always @(posedge clk) begin
    out_item_t e;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected result: total_score %0d status %0d",
               out_data.total_score, out_data.status);
        n_errors++;
      end else begin
        e = pending.pop_front();
        n_checked++;
        if (out_data.total_score !== e.total_score) begin
          $error("total_score: expected %0d, got %0d", e.total_score, out_data.total_score);
          n_errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sess;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    n_items = 0;
    n_checked = 0;
    n_errors = 0;
    n_full = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    clear_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: not built, spare codes, empty and repeated patterns, saturation
    add_row(CMD_TEXT,     2'd0, 0,  1, 0, ST_NOT_BUILT);
    add_row(CMD_END_TEXT, 2'd3, 0,  1, 0, ST_NOT_BUILT);
    add_row(CMD_SPARE6,   2'd3, -1, 1, 0, ST_OK);
    add_row(CMD_SPARE7,   2'd0, -1, 1, 0, ST_OK);
    add_row(CMD_END_PAT,  2'd0, 5,  1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd1, 0,  1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd2, 0,  1, 0, ST_OK);
    add_row(CMD_END_PAT,  2'd0, 32'sh7fff_ffff, 1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd1, 0,  1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd2, 0,  1, 0, ST_OK);
    add_row(CMD_END_PAT,  2'd0, 32'sh7fff_ffff, 1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd2, 0,  1, 0, ST_OK);
    add_row(CMD_END_PAT,  2'd0, 32'sh8000_0000, 1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd3, 0,  1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd3, 0,  1, 0, ST_OK);
    add_row(CMD_END_PAT,  2'd0, 3,  1, 0, ST_OK);
    add_row(CMD_BUILD,    2'd0, 0,  1, 0, ST_OK);
    add_row(CMD_BUILD,    2'd0, 0,  1, 0, ST_OK);
    add_row(CMD_INSERT,   2'd0, 0,  1, 0, ST_OK);
    add_row(CMD_TEXT,     2'd1, 0,  0, 0, ST_OK);
    add_row(CMD_TEXT,     2'd2, 0,  0, 0, ST_OK);
    add_row(CMD_TEXT,     2'd3, 0,  0, 0, ST_OK);
    add_row(CMD_TEXT,     2'd3, 0,  0, 0, ST_OK);
    add_row(CMD_END_TEXT, 2'd0, 0,  0, 0, ST_OK);
    add_row(CMD_CLEAR,    2'd0, 0,  1, 0, ST_OK);
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    sess = 0;
    while (n_items < N_ITEMS) begin
      run_session(sess);
      sess++;
    end
    in_valid <= 1'b0;

    wait (pending.size() == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d items in %0d sessions, checked %0d results, %0d table-full answers.",
             n_items, sess, n_checked, n_full);
    if (n_errors == 0 && pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
